@@ rtl/subject_handle_table_top_defines.svh @@
// Assertion macros for the subject handle table.
// Included by subject_handle_table_top.sv; depends on nothing else.
`ifndef SUBJECT_HANDLE_TABLE_TOP_DEFINES_SVH
`define SUBJECT_HANDLE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define SHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sht_pkg.sv @@
// Package for the subject handle table: codes, entry layout, sequencer states.
// Used by subject_handle_table_top.sv; depends on nothing.
package sht_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 16;

  // Request codes
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Subject kinds
  localparam logic [1:0] KIND_USER  = 2'd0;
  localparam logic [1:0] KIND_GROUP = 2'd1;

  // Status codes
  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_USER_EXISTS = 3'd1;
  localparam logic [2:0] STAT_FULL        = 3'd2;
  localparam logic [2:0] STAT_COLLISION   = 3'd3;
  localparam logic [2:0] STAT_BAD_HANDLE  = 3'd4;

  localparam logic [15:0] USAGE_MAX = 16'hFFFF;
  localparam logic [31:0] HANDLE_ONE = 32'd1;

  // One table entry as held in the memory
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ident;
    logic [31:0] handle;
    logic [15:0] usage;
  } entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE
  } state_t;

endpackage

@@ rtl/subject_handle_table_top.sv @@
// Subject handle table: sequencer, entry memory, scan compare unit, result register.
// Depends on sht_pkg.sv and subject_handle_table_top_defines.svh.
//
//  channel  | handshake             | ports
//  ---------+-----------------------+--------------------------------------------
//  request  | start && !busy        | in_req_type, in_subject_kind, in_subject_ident,
//           |                       | in_handle_in
//  result   | out_valid, one cycle  | out_status, out_handle_out, out_kind_out,
//           |                       | out_ident_out, out_usage_out, out_info_valid
//
// After the accepting edge, SCAN makes one memory read per entry through the
// single read port, DRAIN compares the last entry, and RESOLVE resolves and writes
// back; the result strobe is registered from RESOLVE. busy is high from the cycle
// after accept until the strobe, which comes in the first idle cycle; a new word
// may be accepted at the edge ending it, so words do not overlap.
// Synchronous reset clears the valid bits and the live count and sets the handle
// counter to one; no clearing pass. The result side cannot stall.
`include "subject_handle_table_top_defines.svh"

module subject_handle_table_top #(
  parameter int TABLE_ENTRIES = sht_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_subject_kind,
  input  logic [31:0] in_subject_ident,
  input  logic [31:0] in_handle_in,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_handle_out,
  output logic [1:0]  out_kind_out,
  output logic [31:0] out_ident_out,
  output logic [15:0] out_usage_out,
  output logic        out_info_valid
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int LC_W  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [LC_W-1:0]  LC_ONE   = LC_W'(1);

  // Sequencer
  sht_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  // Latched request
  logic [1:0]  req_r, req_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] ident_r, ident_nxt;
  logic [31:0] cmp_handle_r, cmp_handle_nxt;
  logic        root_r, root_nxt;

  // Table state
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]              next_handle_r, next_handle_nxt;
  logic [LC_W-1:0]          live_count_r, live_count_nxt;
  sht_pkg::entry_t          mem [TABLE_ENTRIES];

  // Memory write port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  sht_pkg::entry_t  mem_wdata;

  // Read stage
  sht_pkg::entry_t rd_entry_r;
  logic            rd_valid_r;
  logic            pipe_vld_r;

  // Scan results
  logic             sel_hit_r, sel_hit_nxt;
  logic [IDX_W-1:0] sel_idx_r, sel_idx_nxt;
  sht_pkg::entry_t  sel_entry_r, sel_entry_nxt;
  logic             hd_hit_r, hd_hit_nxt;
  logic             free_hit_r, free_hit_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] pipe_idx_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  sht_pkg::entry_t out_entry_r, out_entry_nxt;
  logic        out_info_r, out_info_nxt;

  // Compare unit
  logic hand_eq;
  logic id_eq;
  logic prim_match;
  logic [15:0] usage_inc;
  logic accept;

  assign accept = start && (state_r == sht_pkg::ST_IDLE);
  assign busy   = (state_r != sht_pkg::ST_IDLE);

  assign hand_eq    = (rd_entry_r.handle == cmp_handle_r);
  assign id_eq      = (rd_entry_r.kind == kind_r) && (rd_entry_r.ident == ident_r);
  assign prim_match = rd_valid_r && ((req_r == sht_pkg::REQ_CREATE) ? id_eq : hand_eq);
  assign usage_inc  = (sel_entry_r.usage == sht_pkg::USAGE_MAX) ?
                      sel_entry_r.usage : sel_entry_r.usage + 16'd1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sht_pkg::ST_IDLE: begin
        if (start) state_nxt = sht_pkg::ST_SCAN;
      end
      sht_pkg::ST_SCAN: begin
        if (cnt_r == IDX_LAST) state_nxt = sht_pkg::ST_DRAIN;
      end
      sht_pkg::ST_DRAIN:   state_nxt = sht_pkg::ST_RESOLVE;
      sht_pkg::ST_RESOLVE: state_nxt = sht_pkg::ST_IDLE;
      default:             state_nxt = sht_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_nxt         = cnt_r;
    req_nxt         = req_r;
    kind_nxt        = kind_r;
    ident_nxt       = ident_r;
    cmp_handle_nxt  = cmp_handle_r;
    root_nxt        = root_r;
    valid_nxt       = valid_r;
    next_handle_nxt = next_handle_r;
    live_count_nxt  = live_count_r;
    sel_hit_nxt     = sel_hit_r;
    sel_idx_nxt     = sel_idx_r;
    sel_entry_nxt   = sel_entry_r;
    hd_hit_nxt      = hd_hit_r;
    free_hit_nxt    = free_hit_r;
    free_idx_nxt    = free_idx_r;
    mem_we          = 1'b0;
    mem_waddr       = sel_idx_r;
    mem_wdata       = sel_entry_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = sht_pkg::STAT_BAD_HANDLE;
    out_entry_nxt   = '0;
    out_info_nxt    = 1'b0;

    // Latch the word and pick the handle to look for
    if (accept) begin
      cnt_nxt      = '0;
      req_nxt      = in_req_type;
      kind_nxt     = in_subject_kind;
      ident_nxt    = in_subject_ident;
      root_nxt     = (in_subject_kind == sht_pkg::KIND_USER) && (in_subject_ident == 32'd0);
      sel_hit_nxt  = 1'b0;
      hd_hit_nxt   = 1'b0;
      free_hit_nxt = 1'b0;
      if (in_req_type == sht_pkg::REQ_CREATE) begin
        cmp_handle_nxt = root_nxt ? 32'd0 : next_handle_r;
      end else begin
        cmp_handle_nxt = in_handle_in;
      end
    end

    // Read address counter
    if (state_r == sht_pkg::ST_SCAN && cnt_r != IDX_LAST) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end

    // Compare stage: first primary match, any handle match, lowest free slot
    if (pipe_vld_r) begin
      if (prim_match && !sel_hit_r) begin
        sel_hit_nxt   = 1'b1;
        sel_idx_nxt   = pipe_idx_r;
        sel_entry_nxt = rd_entry_r;
      end
      if (rd_valid_r && hand_eq) hd_hit_nxt = 1'b1;
      if (!rd_valid_r && !free_hit_r) begin
        free_hit_nxt = 1'b1;
        free_idx_nxt = pipe_idx_r;
      end
    end

    // Resolve and write back
    if (state_r == sht_pkg::ST_RESOLVE) begin
      out_valid_nxt = 1'b1;
      unique case (req_r)
        sht_pkg::REQ_CREATE: begin
          if (sel_hit_r) begin
            if (kind_r == sht_pkg::KIND_USER) begin
              out_status_nxt = sht_pkg::STAT_USER_EXISTS;
            end else if (kind_r == sht_pkg::KIND_GROUP) begin
              mem_we              = 1'b1;
              mem_waddr           = sel_idx_r;
              mem_wdata           = sel_entry_r;
              mem_wdata.usage     = usage_inc;
              out_status_nxt      = sht_pkg::STAT_OK;
              out_entry_nxt       = mem_wdata;
              out_info_nxt        = 1'b1;
            end else begin
              out_status_nxt = sht_pkg::STAT_OK;
            end
          end else if (!free_hit_r) begin
            out_status_nxt = sht_pkg::STAT_FULL;
          end else begin
            if (!root_r) next_handle_nxt = next_handle_r + sht_pkg::HANDLE_ONE;
            if (hd_hit_r) begin
              out_status_nxt = sht_pkg::STAT_COLLISION;
            end else begin
              mem_we                = 1'b1;
              mem_waddr             = free_idx_r;
              mem_wdata.kind        = kind_r;
              mem_wdata.ident       = ident_r;
              mem_wdata.handle      = cmp_handle_r;
              mem_wdata.usage       = 16'd1;
              valid_nxt[free_idx_r] = 1'b1;
              live_count_nxt        = live_count_r + LC_ONE;
              out_status_nxt        = sht_pkg::STAT_OK;
              out_entry_nxt         = mem_wdata;
              out_info_nxt          = 1'b1;
            end
          end
        end
        sht_pkg::REQ_DELETE: begin
          if (sel_hit_r) begin
            valid_nxt[sel_idx_r] = 1'b0;
            if (live_count_r != '0) live_count_nxt = live_count_r - LC_ONE;
            out_status_nxt = sht_pkg::STAT_OK;
          end
        end
        sht_pkg::REQ_QUERY: begin
          if (sel_hit_r) begin
            out_status_nxt = sht_pkg::STAT_OK;
            out_entry_nxt  = sel_entry_r;
            out_info_nxt   = 1'b1;
          end
        end
        default: out_status_nxt = sht_pkg::STAT_BAD_HANDLE;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sht_pkg::ST_IDLE;
      cnt_r         <= '0;
      valid_r       <= '0;
      next_handle_r <= sht_pkg::HANDLE_ONE;
      live_count_r  <= '0;
      pipe_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      valid_r       <= valid_nxt;
      next_handle_r <= next_handle_nxt;
      live_count_r  <= live_count_nxt;
      pipe_vld_r    <= (state_r == sht_pkg::ST_SCAN);
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    kind_r       <= kind_nxt;
    ident_r      <= ident_nxt;
    cmp_handle_r <= cmp_handle_nxt;
    root_r       <= root_nxt;
    sel_hit_r    <= sel_hit_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_entry_r  <= sel_entry_nxt;
    hd_hit_r     <= hd_hit_nxt;
    free_hit_r   <= free_hit_nxt;
    free_idx_r   <= free_idx_nxt;
    pipe_idx_r   <= cnt_r;
    rd_valid_r   <= valid_r[cnt_r];
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_info_r   <= out_info_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_entry_r <= mem[cnt_r];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle_out = out_entry_r.handle;
  assign out_kind_out   = out_entry_r.kind;
  assign out_ident_out  = out_entry_r.ident;
  assign out_usage_out  = out_entry_r.usage;
  assign out_info_valid = out_info_r;

  // Checks
  `SHT_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid_r, !busy, "result while busy")
  `SHT_ASSERT_NOW(a_live_count, clk, rst_n, 1'b1, live_count_r == LC_W'($countones(valid_r)), "live count mismatch")
  `SHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted word did not raise busy")
  `SHT_ASSERT_NOW(a_info_ok, clk, rst_n, out_valid_r && out_info_r, out_status_r == sht_pkg::STAT_OK, "info with error status")

endmodule
